// ===== src/tcw_pkg.sv =====
// Shared types and constants for the text console cell writer.
// Holds the port payload structs, the front-to-back command and the back-end states.
// No dependencies.
package tcw_pkg;

    localparam int TCW_COLUMNS     = 80;
    localparam int TCW_ROWS        = 24;
    localparam int TCW_QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] ATTR_RESET   = 8'h07;

    localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
    localparam logic [2:0] OP_MOVE_LEFT  = 3'd1;
    localparam logic [2:0] OP_MOVE_RIGHT = 3'd2;
    localparam logic [2:0] OP_SET_POS    = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;
    localparam logic [2:0] OP_READ_CELL  = 3'd5;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] char_code;
        logic [6:0] column;
        logic [4:0] row;
    } t_in_item;

    typedef struct packed {
        logic [6:0] cursor_column;
        logic [4:0] cursor_row;
        logic       scrolled;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } t_out_item;

    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_LEFT,
        CMD_RIGHT,
        CMD_SETPOS,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] ch;
        logic [6:0] col;
        logic [4:0] row;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_INIT,
        BS_IDLE,
        BS_FILL,
        BS_EMIT
    } t_back_state;

endpackage

// ===== src/text_console_cell_writer_core.sv =====
// Text console cell writer, top level.
// Requests enter on the input channel and a result leaves on the output channel for each one.
// Channels are valid/ready; the attribute register has a plain write enable.
// A request passes the command queue, the back end's IDLE state, a FILL pass if needed,
//   EMIT and the result register; the back end pops another request only after it loads.
// A scroll refills the new bottom row (rows sit in a ring, only the top pointer moves);
//   clear refills every cell, one cell written per cycle on the single memory write port.
// After reset a clearing pass over all COLUMNS*ROWS cells (1920 by default) fills the
//   screen with spaces in attribute 0x07; input ready stays low until it ends.
//   The attribute register takes writes during that pass.
// A two-entry command queue sits between decode and execution, and the result
//   sits in an output register; a stalled receiver holds the result and the back
//   end, while the queue keeps taking requests until it is full.
// The user makes attribute writes only while nothing is in flight; the block does not check.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back.
module text_console_cell_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS     = TCW_COLUMNS,
    parameter int ROWS        = TCW_ROWS,
    parameter int QUEUE_DEPTH = TCW_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item
);

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_head;
    logic q_pop;
    logic init_busy;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_ready (o_in_ready),
        .i_hold     (init_busy),
        .i_full     (q_full),
        .o_push     (push),
        .o_push_cmd (push_cmd)
    );

    tcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_head     (q_head),
        .i_pop      (q_pop)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_head),
        .o_q_pop     (q_pop),
        .o_init_busy (init_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== src/tcw_front.sv =====
// Front end: takes requests, decodes the operation and saturates the cell position.
// Depends on tcw_pkg.
module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = TCW_COLUMNS,
    parameter int ROWS    = TCW_ROWS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    output logic     o_in_ready,
    input  logic     i_hold,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_push_cmd
);

    logic [6:0] col_sat;
    logic [4:0] row_sat;
    t_cmd_kind  kind;
    logic       r_ready_en;

    // ready held low until r_ready_en is set after reset release
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_en <= 1'b0;
        end else begin
            r_ready_en <= 1'b1;
        end
    end

    assign col_sat = (32'(i_in_item.column) > 32'(COLUMNS - 1)) ? 7'(COLUMNS - 1)
                                                                : i_in_item.column;
    assign row_sat = (32'(i_in_item.row) > 32'(ROWS - 1)) ? 5'(ROWS - 1) : i_in_item.row;

    always_comb begin
        unique case (i_in_item.operation)
            OP_PUT_CHAR:   kind = (i_in_item.char_code == CHAR_NEWLINE) ? CMD_NEWLINE : CMD_PUT;
            OP_MOVE_LEFT:  kind = CMD_LEFT;
            OP_MOVE_RIGHT: kind = CMD_RIGHT;
            OP_SET_POS:    kind = CMD_SETPOS;
            OP_CLEAR:      kind = CMD_CLEAR;
            OP_READ_CELL:  kind = CMD_READ;
            default:       kind = CMD_NOP;
        endcase
    end

    assign o_in_ready      = r_ready_en && !i_hold && !i_full;
    assign o_push          = i_in_valid && o_in_ready;
    assign o_push_cmd.kind = kind;
    assign o_push_cmd.ch   = i_in_item.char_code;
    assign o_push_cmd.col  = col_sat;
    assign o_push_cmd.row  = row_sat;

endmodule

// ===== src/tcw_queue.sv =====
// Short command queue between the front and back ends.
// Depends on tcw_pkg.
module tcw_queue
    import tcw_pkg::*;
#(
    parameter int DEPTH = TCW_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head,
    input  logic i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    t_cmd          r_entry [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [NW-1:0] r_count;
    logic          do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_entry[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wp] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + NW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

endmodule

// ===== src/tcw_back.sv =====
// Back end: cursor, attribute register, cell memory with row ring, fill sequencer, result register.
// Depends on tcw_pkg.
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = TCW_COLUMNS,
    parameter int ROWS    = TCW_ROWS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_q_pop,
    output logic      o_init_busy,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int RW1   = RW + 1;

    t_back_state   r_state;
    t_back_state   n_state;
    logic [7:0]    r_text_attr;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [RW-1:0] r_top;
    logic [AW-1:0] r_fill_addr;
    logic [AW-1:0] r_fill_end;
    logic [7:0]    r_fill_attr;
    logic          r_res_scroll;
    logic          r_res_read;
    logic          r_out_valid;
    t_out_item     r_out;
    logic [15:0]   r_mem [CELLS];
    logic [15:0]   r_rd_data;

    logic          pop;
    logic          advancing;
    logic          col_last;
    logic          row_last;
    logic          wrap;
    logic [CW-1:0] adv_col;
    logic [RW-1:0] adv_row;
    logic          adv_scroll;
    logic          fill_done;
    logic          out_load;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] scroll_base;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] top,
                                                input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        logic [RW1-1:0] sum;
        logic [RW1-1:0] phys;
        sum  = {1'b0, top} + {1'b0, row};
        phys = (sum >= RW1'(ROWS)) ? sum - RW1'(ROWS) : sum;
        return AW'(AW'(phys) * AW'(COLUMNS) + AW'(col));
    endfunction

    assign pop        = (r_state == BS_IDLE) && i_q_valid;
    assign advancing  = (i_q_cmd.kind == CMD_PUT) || (i_q_cmd.kind == CMD_NEWLINE)
                        || (i_q_cmd.kind == CMD_RIGHT);
    assign col_last   = (r_col == CW'(COLUMNS - 1));
    assign row_last   = (r_row == RW'(ROWS - 1));
    assign wrap       = (i_q_cmd.kind == CMD_NEWLINE) || col_last;
    assign adv_col    = wrap ? '0 : r_col + CW'(1);
    assign adv_row    = (wrap && !row_last) ? r_row + RW'(1) : r_row;
    assign adv_scroll = wrap && row_last;
    assign fill_done  = (r_fill_addr == r_fill_end);
    assign out_load   = (r_state == BS_EMIT) && (!r_out_valid || i_out_ready);
    // the old top row becomes the new bottom row
    assign scroll_base = cell_addr(r_top, '0, '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_INIT: begin
                if (fill_done) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (i_q_valid) begin
                    if ((i_q_cmd.kind == CMD_CLEAR) || (advancing && adv_scroll)) begin
                        n_state = BS_FILL;
                    end else begin
                        n_state = BS_EMIT;
                    end
                end
            end
            BS_FILL: begin
                if (fill_done) begin
                    n_state = BS_EMIT;
                end
            end
            BS_EMIT: begin
                if (out_load) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_INIT;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_fill_addr;
        mem_wdata = {CHAR_SPACE, r_fill_attr};
        mem_re    = 1'b0;
        mem_raddr = cell_addr(r_top, RW'(i_q_cmd.row), CW'(i_q_cmd.col));
        unique case (r_state)
            BS_INIT, BS_FILL: begin
                mem_we = 1'b1;
            end
            BS_IDLE: begin
                if (pop && (i_q_cmd.kind == CMD_PUT)) begin
                    mem_we    = 1'b1;
                    mem_waddr = cell_addr(r_top, r_row, r_col);
                    mem_wdata = {i_q_cmd.ch, r_text_attr};
                end
                mem_re = pop && (i_q_cmd.kind == CMD_READ);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign o_q_pop     = (r_state == BS_IDLE);
    assign o_init_busy = (r_state == BS_INIT);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.cursor_column <= 7'(r_col);
            r_out.cursor_row    <= 5'(r_row);
            r_out.scrolled      <= r_res_scroll;
            r_out.cell_char     <= r_res_read ? r_rd_data[15:8] : 8'd0;
            r_out.cell_attr     <= r_res_read ? r_rd_data[7:0] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BS_INIT;
            r_text_attr  <= ATTR_RESET;
            r_col        <= '0;
            r_row        <= '0;
            r_top        <= '0;
            r_fill_addr  <= '0;
            r_fill_end   <= AW'(CELLS - 1);
            r_fill_attr  <= ATTR_RESET;
            r_res_scroll <= 1'b0;
            r_res_read   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_text_attr <= i_cfg_data;
            end
            if ((r_state == BS_INIT) || (r_state == BS_FILL)) begin
                r_fill_addr <= r_fill_addr + AW'(1);
            end
            if (pop) begin
                r_res_scroll <= advancing && adv_scroll;
                r_res_read   <= (i_q_cmd.kind == CMD_READ);
                unique case (i_q_cmd.kind)
                    CMD_PUT, CMD_NEWLINE, CMD_RIGHT: begin
                        r_col <= adv_col;
                        r_row <= adv_row;
                        if (adv_scroll) begin
                            r_top       <= (r_top == RW'(ROWS - 1)) ? '0 : r_top + RW'(1);
                            r_fill_addr <= scroll_base;
                            r_fill_end  <= scroll_base + AW'(COLUMNS - 1);
                            r_fill_attr <= r_text_attr;
                        end
                    end
                    CMD_LEFT: begin
                        if (r_col != '0) begin
                            r_col <= r_col - CW'(1);
                        end else if (r_row != '0) begin
                            r_col <= CW'(COLUMNS - 1);
                            r_row <= r_row - RW'(1);
                        end
                    end
                    CMD_SETPOS: begin
                        r_col <= CW'(i_q_cmd.col);
                        r_row <= RW'(i_q_cmd.row);
                    end
                    CMD_CLEAR: begin
                        r_fill_addr <= '0;
                        r_fill_end  <= AW'(CELLS - 1);
                        r_fill_attr <= r_text_attr;
                    end
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) <= 32'(COLUMNS - 1)) && (32'(r_row) <= 32'(ROWS - 1)))
        else $error("cursor outside the screen");

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_top) <= 32'(ROWS - 1))
        else $error("row ring top outside the screen");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == BS_INIT) || (r_state == BS_FILL)) |-> (r_fill_addr <= r_fill_end))
        else $error("fill sweep ran past its end");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.scrolled) |->
            ((r_out.cursor_column == 7'd0) && (r_out.cursor_row == 5'(ROWS - 1))))
        else $error("scroll reported with cursor off the start of the bottom row");

    a_no_write_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_EMIT) |-> !mem_we)
        else $error("memory written while a result is pending");
`endif

endmodule
